// ===== design/ckblit_pkg.sv =====
`timescale 1ns / 1ps
// Package for the clipped colour-key blitter: opcodes, status codes,
// register indexes, reset values and the sequencer state type.
// Depends on nothing.
package ckblit_pkg;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_BLIT = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_CLIPPED  = 2'd1;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_KEY_COLOR    = 2'd2;

   localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd576;
   localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd512;
   localparam logic [31:0] KEY_COLOR_RESET    = 32'hFFFF00FF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLIP,
      ST_MULT,
      ST_SUM,
      ST_REDUCE,
      ST_COPY,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

// ===== design/clipped_color_key_blit_core.sv =====
`timescale 1ns / 1ps
// Top level of the clipped colour-key blitter: sprite and frame memories,
// the blit sequencer and the register port. Depends on ckblit_pkg.

// One item is handled at a time. A load or a read goes from transfer to a
// result through the finish state. A blit clips, forms the two row products,
// sums them and reduces the first sprite index modulo the store size by a
// reciprocal multiply, then copies the clipped rectangle one pixel per cycle,
// drains the sprite read pipeline and registers the result. A blit that is
// clipped away or refused goes from the clip state straight to the result.
// The pixel rate is set by the single read port of the sprite memory and the
// single write port of the frame memory. A finished result waits in an output
// register, and the next item is taken while it waits. Register writes must
// only be made while no item is in flight.
module clipped_color_key_blit_core #(
   parameter int unsigned SPRITE_WORDS = 65536,
   parameter int unsigned FRAME_WORDS  = 524288
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [18:0]        req_address,
   input  logic [31:0]        req_pixel,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [9:0]         req_sprite_width,
   input  logic [9:0]         req_sprite_height,
   input  logic [15:0]        req_sprite_base,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_read_data,
   output logic [20:0]        rsp_pixels_written,
   output logic [1:0]         rsp_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import ckblit_pkg::*;

   localparam int unsigned SA = $clog2(SPRITE_WORDS);
   localparam int unsigned FA = $clog2(FRAME_WORDS);
   localparam logic [SA:0] SLIM = (SA + 1)'(SPRITE_WORDS);
   // Reciprocal of the store size scaled by 2^21; the start index is below 2^21.
   localparam logic [11:0] RECIP = 12'((32'd1 << 21) / SPRITE_WORDS);

   // Storage.
   logic [31:0] sprite_mem [SPRITE_WORDS];
   logic [31:0] frame_mem  [FRAME_WORDS];

   state_type state_ff, state_in;

   logic [10:0] fw_ff, fh_ff;
   logic [31:0] key_ff;

   logic signed [15:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [9:0]  sw_ff, sw_in, sh_ff, sh_in;
   logic [15:0] base_ff, base_in;
   logic        read_hit_ff, read_hit_in;
   logic [1:0]  status_ff, status_in;
   logic [10:0] cx1_ff, cx1_in, cy1_ff, cy1_in;
   logic [9:0]  cw_ff, cw_in, ch_ff, ch_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [19:0] sprod_ff, sprod_in;
   logic [21:0] dprod_ff, dprod_in;
   logic [20:0] rem_ff, rem_in;
   logic        step_ff, step_in;
   logic [10:0] quot_ff, quot_in;
   logic [SA-1:0] rsi_ff, rsi_in, si_ff, si_in;
   logic [FA-1:0] drow_ff, drow_in, di_ff, di_in;
   logic [9:0]  col_ff, col_in, row_ff, row_in;
   logic        pix_valid_ff, pix_valid_in;
   logic [FA-1:0] pix_addr_ff, pix_addr_in;
   logic [20:0] count_ff, count_in;
   logic [31:0] sprite_rd_ff, frame_rd_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic [20:0] rsp_pixels_written_ff, rsp_pixels_written_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic req_fire, sprite_we, sprite_re, frame_we, frame_re, csr_we;

   // Clip arithmetic, 18-bit signed so that the far corner never wraps.
   logic signed [17:0] x1_s, y1_s, x2_s, y2_s, fw_s, fh_s, neg_x1, neg_y1;
   logic [21:0] frame_area;
   logic        off_screen;
   logic [10:0] cx2, cy2;

   logic [31:0] quot_prod, quot_back, red_rem;
   logic [20:0] rem_next;
   logic [SA:0] row_sum, si_inc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign sprite_we = req_fire && (req_opcode == OP_LOAD)
                      && (21'(req_address) < 21'(SPRITE_WORDS));
   assign frame_re  = req_fire && (req_opcode == OP_READ)
                      && (21'(req_address) < 21'(FRAME_WORDS));
   assign sprite_re = (state_ff == ST_COPY);
   assign frame_we  = pix_valid_ff && (sprite_rd_ff != key_ff);

   // Sprite memory: loads write, the copy loop reads.
   always_ff @(posedge clock) begin
      if (sprite_we) begin
         sprite_mem[SA'(req_address)] <= req_pixel;
      end
      if (sprite_re) begin
         sprite_rd_ff <= sprite_mem[si_ff];
      end
   end

   // Frame memory: the copy loop writes in the cycle after the sprite read.
   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[pix_addr_ff] <= sprite_rd_ff;
      end
      if (frame_re) begin
         frame_rd_ff <= frame_mem[FA'(req_address)];
      end
   end

   // Register port.
   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[3:2])
         CSR_FRAME_WIDTH:  prdata = {21'd0, fw_ff};
         CSR_FRAME_HEIGHT: prdata = {21'd0, fh_ff};
         CSR_KEY_COLOR:    prdata = key_ff;
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= FRAME_WIDTH_RESET;
         fh_ff  <= FRAME_HEIGHT_RESET;
         key_ff <= KEY_COLOR_RESET;
      end else if (csr_we) begin
         unique case (paddr[3:2])
            CSR_FRAME_WIDTH:  fw_ff  <= pwdata[10:0];
            CSR_FRAME_HEIGHT: fh_ff  <= pwdata[10:0];
            CSR_KEY_COLOR:    key_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Clipping terms, used in the clip state.
   always_comb begin
      x1_s       = 18'(pos_x_ff);
      y1_s       = 18'(pos_y_ff);
      x2_s       = x1_s + $signed({8'd0, sw_ff}) - 18'sd1;
      y2_s       = y1_s + $signed({8'd0, sh_ff}) - 18'sd1;
      fw_s       = $signed({7'd0, fw_ff});
      fh_s       = $signed({7'd0, fh_ff});
      neg_x1     = -x1_s;
      neg_y1     = -y1_s;
      frame_area = 22'(fw_ff) * 22'(fh_ff);
      off_screen = (sw_ff == 10'd0) || (sh_ff == 10'd0) || (fw_ff == 11'd0)
                   || (fh_ff == 11'd0) || (x1_s >= fw_s) || (x2_s < 18'sd0)
                   || (y1_s >= fh_s) || (y2_s < 18'sd0);
      cx2        = (x2_s >= fw_s) ? fw_ff - 11'd1 : x2_s[10:0];
      cy2        = (y2_s >= fh_s) ? fh_ff - 11'd1 : y2_s[10:0];
   end

   // The first sprite index modulo the store size: the reciprocal multiply gives
   // a quotient that is exact or one short, and one subtraction corrects it.
   always_comb begin
      quot_prod = 32'(rem_ff) * 32'(RECIP);
      quot_back = 32'(quot_ff) * 32'(SPRITE_WORDS);
      red_rem   = 32'(rem_ff) - quot_back;
      if (red_rem >= 32'(SPRITE_WORDS)) begin
         red_rem = red_rem - 32'(SPRITE_WORDS);
      end
      rem_next = red_rem[20:0];
      row_sum  = (SA + 1)'(rsi_ff) + (SA + 1)'(sw_ff);
      if (row_sum >= SLIM) begin
         row_sum = row_sum - SLIM;
      end
      si_inc   = (SA + 1)'(si_ff) + 1'b1;
      if (si_inc == SLIM) begin
         si_inc = '0;
      end
   end

   // Sequencer: next state and datapath.
   always_comb begin
      state_in    = state_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      sw_in       = sw_ff;
      sh_in       = sh_ff;
      base_in     = base_ff;
      read_hit_in = read_hit_ff;
      status_in   = status_ff;
      cx1_in      = cx1_ff;
      cy1_in      = cy1_ff;
      cw_in       = cw_ff;
      ch_in       = ch_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      sprod_in    = sprod_ff;
      dprod_in    = dprod_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      quot_in     = quot_ff;
      rsi_in      = rsi_ff;
      si_in       = si_ff;
      drow_in     = drow_ff;
      di_in       = di_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pix_valid_in = (state_ff == ST_COPY);
      pix_addr_in  = di_ff;
      count_in     = frame_we ? count_ff + 21'd1 : count_ff;

      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      rsp_read_data_in      = rsp_read_data_ff;
      rsp_pixels_written_in = rsp_pixels_written_ff;
      rsp_status_in         = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_x_in    = req_pos_x;
               pos_y_in    = req_pos_y;
               sw_in       = req_sprite_width;
               sh_in       = req_sprite_height;
               base_in     = req_sprite_base;
               read_hit_in = frame_re;
               status_in   = STATUS_DONE;
               count_in    = '0;
               state_in    = (req_opcode == OP_BLIT) ? ST_CLIP : ST_FINISH;
            end
         end
         ST_CLIP: begin
            cx1_in = (x1_s < 18'sd0) ? 11'd0 : x1_s[10:0];
            cy1_in = (y1_s < 18'sd0) ? 11'd0 : y1_s[10:0];
            sx_in  = (x1_s < 18'sd0) ? neg_x1[9:0] : 10'd0;
            sy_in  = (y1_s < 18'sd0) ? neg_y1[9:0] : 10'd0;
            cw_in  = 10'(cx2 - cx1_in);
            ch_in  = 10'(cy2 - cy1_in);
            if (frame_area > 22'(FRAME_WORDS)) begin
               status_in = STATUS_OVERSIZE;
               state_in  = ST_FINISH;
            end else if (off_screen) begin
               status_in = STATUS_CLIPPED;
               state_in  = ST_FINISH;
            end else begin
               state_in  = ST_MULT;
            end
         end
         ST_MULT: begin
            sprod_in = 20'(sy_ff) * 20'(sw_ff);
            dprod_in = 22'(cy1_ff) * 22'(fw_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rem_in   = 21'(base_ff) + 21'(sprod_ff) + 21'(sx_ff);
            drow_in  = FA'(dprod_ff + 22'(cx1_ff));
            di_in    = FA'(dprod_ff + 22'(cx1_ff));
            step_in  = 1'b1;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            step_in = 1'b0;
            if (step_ff) begin
               quot_in = quot_prod[31:21];
            end else begin
               rsi_in   = rem_next[SA-1:0];
               si_in    = rem_next[SA-1:0];
               col_in   = '0;
               row_in   = '0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (col_ff == cw_ff) begin
               col_in = '0;
               if (row_ff == ch_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in  = row_ff + 10'd1;
                  rsi_in  = row_sum[SA-1:0];
                  si_in   = row_sum[SA-1:0];
                  drow_in = drow_ff + FA'(fw_ff);
                  di_in   = drow_ff + FA'(fw_ff);
               end
            end else begin
               col_in = col_ff + 10'd1;
               si_in  = si_inc[SA-1:0];
               di_in  = di_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // The last pixel is written at the end of this cycle.
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_read_data_in      = read_hit_ff ? frame_rd_ff : 32'd0;
               rsp_pixels_written_in = count_ff;
               rsp_status_in         = status_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff              <= pos_x_in;
      pos_y_ff              <= pos_y_in;
      sw_ff                 <= sw_in;
      sh_ff                 <= sh_in;
      base_ff               <= base_in;
      read_hit_ff           <= read_hit_in;
      status_ff             <= status_in;
      cx1_ff                <= cx1_in;
      cy1_ff                <= cy1_in;
      cw_ff                 <= cw_in;
      ch_ff                 <= ch_in;
      sx_ff                 <= sx_in;
      sy_ff                 <= sy_in;
      sprod_ff              <= sprod_in;
      dprod_ff              <= dprod_in;
      rem_ff                <= rem_in;
      step_ff               <= step_in;
      quot_ff               <= quot_in;
      rsi_ff                <= rsi_in;
      si_ff                 <= si_in;
      drow_ff               <= drow_in;
      di_ff                 <= di_in;
      col_ff                <= col_in;
      row_ff                <= row_in;
      pix_addr_ff           <= pix_addr_in;
      count_ff              <= count_in;
      rsp_read_data_ff      <= rsp_read_data_in;
      rsp_pixels_written_ff <= rsp_pixels_written_in;
      rsp_status_ff         <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_pixels_written = rsp_pixels_written_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef SYNTHESIS
   // Frame writes come only from the copy pipeline.
   a_pix_in_copy: assert property (@(posedge clock) disable iff (reset)
      pix_valid_ff |-> (state_ff == ST_COPY || state_ff == ST_DRAIN))
      else $error("frame write outside the copy loop");

   // A result is only ever produced from the finish state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside the finish state");

   // The source index stays inside the sprite store while copying.
   a_si_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |-> (SA + 1)'(si_ff) < SLIM)
      else $error("sprite index beyond the store");
`endif

endmodule
